// File: hdl/sfpp_pkg.sv
// ---------------------------------------------------------------------------
// Serial frame pair parser package
// Types and constants shared by the parser and its output buffer.
// ---------------------------------------------------------------------------
package sfpp_pkg;

    // Header bytes that open a frame.
    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;

    // Payload positions that are kept.
    localparam int STORE_DEPTH = 8;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Entries of the output buffer.
    localparam int OUT_DEPTH = 2;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    // Frame phases after the header has been found.
    typedef enum logic [1:0] {
        PH_LENGTH   = 2'd0,
        PH_PAYLOAD  = 2'd1,
        PH_CHECKSUM = 2'd2,
        PH_TRAILER  = 2'd3
    } t_phase;

    // One result: the two decoded values.
    typedef struct packed {
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
    } t_pair;

endpackage

// File: hdl/sfpp_if.sv
// ---------------------------------------------------------------------------
// Serial frame pair parser channels
// Valid/ready channels for received bytes and for decoded value pairs.
// ---------------------------------------------------------------------------

// Received byte channel.
interface sfpp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded pair channel.
interface sfpp_pair_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;

    modport source (output valid, output first_value, output second_value, input ready);
    modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

// File: hdl/sfpp_out_buf.sv
// ---------------------------------------------------------------------------
// Serial frame pair parser output buffer
// Two-entry queue between the parser and the result channel, so that the
// parser keeps taking bytes while a result waits to be transferred.
// ---------------------------------------------------------------------------
module sfpp_out_buf
    import sfpp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_pair               i_data,
    output logic                o_full,
    sfpp_pair_if.source         o_pair
);

    t_pair              r_mem [OUT_DEPTH];
    logic [OUT_AW-1:0]  r_wr_ptr;
    logic [OUT_AW-1:0]  r_rd_ptr;
    logic [OUT_CW-1:0]  r_count;
    logic               w_pop;

    assign w_pop        = o_pair.valid && o_pair.ready;
    assign o_full       = (r_count == OUT_CW'(OUT_DEPTH));
    assign o_pair.valid = (r_count != '0);
    assign o_pair.first_value  = r_mem[r_rd_ptr].first_value;
    assign o_pair.second_value = r_mem[r_rd_ptr].second_value;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == OUT_AW'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == OUT_AW'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The fill level never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OUT_CW'(OUT_DEPTH))
        else $error("output buffer fill level beyond depth");

    // The parser never pushes into a full buffer.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full output buffer");

    // A transfer out without a push lowers the fill level by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("fill level wrong after transfer out");

endmodule

// File: hdl/serial_frame_pair_parser.sv
// ---------------------------------------------------------------------------
// Serial frame pair parser
// Finds 0x55 0xAA framed packets in a byte stream and emits two signed
// 32-bit little-endian values from the first eight payload bytes.
// ---------------------------------------------------------------------------
// One received byte is taken per clock cycle while the output buffer is not
// full: the frame state and the eight-byte payload store are registered from each byte.
// A frame is a 0x55 0xAA header, a length byte L, max(1, L-1) payload
// bytes, one checksum byte and two trailer bytes; checksum and trailer are
// not checked, and the checksum byte lands in payload position L-1 when L
// is between one and eight. On the second trailer byte one result is
// queued in a two-entry output buffer. The byte channel is held off only
// while both buffer entries wait to be transferred. Payload positions that
// a short frame does not write keep their earlier values; reset clears them.
// ---------------------------------------------------------------------------
module serial_frame_pair_parser
    import sfpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfpp_rx_if.sink     i_rx,
    sfpp_pair_if.source o_pair
);

    // Frame state.
    logic           r_hunting,      n_hunting;
    logic [7:0]     r_prev_byte,    n_prev_byte;
    t_phase         r_phase,        n_phase;
    logic [7:0]     r_frame_len,    n_frame_len;
    logic [7:0]     r_pay_count,    n_pay_count;
    logic           r_trailer_seen, n_trailer_seen;
    logic [7:0]     r_store [STORE_DEPTH];

    logic                w_accept;
    logic                w_full;
    logic [7:0]          w_byte;
    logic [7:0]          w_need;
    logic [8:0]          w_count_inc;
    logic [7:0]          w_len_m1;
    logic                w_emit;
    logic                w_store_we;
    logic [STORE_AW-1:0] w_store_idx;
    t_pair               w_pair;

    assign i_rx.ready = !w_full;
    assign w_accept   = i_rx.valid && !w_full;
    assign w_byte     = i_rx.rx_byte;

    assign w_need      = (r_frame_len <= 8'd1) ? 8'd1 : r_frame_len - 8'd1;
    assign w_count_inc = {1'b0, r_pay_count} + 9'd1;
    assign w_len_m1    = r_frame_len - 8'd1;

    // Next frame state.
    always_comb begin
        n_hunting      = r_hunting;
        n_prev_byte    = r_prev_byte;
        n_phase        = r_phase;
        n_frame_len    = r_frame_len;
        n_pay_count    = r_pay_count;
        n_trailer_seen = r_trailer_seen;
        if (w_accept) begin
            if (r_hunting) begin
                if (w_byte == HDR_SECOND) begin
                    if (r_prev_byte == HDR_FIRST) begin
                        n_hunting      = 1'b0;
                        n_phase        = PH_LENGTH;
                        n_pay_count    = '0;
                        n_trailer_seen = 1'b0;
                    end
                end else begin
                    n_prev_byte = w_byte;
                end
            end else begin
                unique case (r_phase)
                    PH_LENGTH: begin
                        n_frame_len = w_byte;
                        n_pay_count = '0;
                        n_phase     = PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        if (w_count_inc >= {1'b0, w_need}) begin
                            n_pay_count = '0;
                            n_phase     = PH_CHECKSUM;
                        end else begin
                            n_pay_count = w_count_inc[7:0];
                        end
                    end
                    PH_CHECKSUM: begin
                        n_phase = PH_TRAILER;
                    end
                    PH_TRAILER: begin
                        if (!r_trailer_seen) begin
                            n_trailer_seen = 1'b1;
                        end else begin
                            n_hunting      = 1'b1;
                            n_prev_byte    = '0;
                            n_phase        = PH_LENGTH;
                            n_frame_len    = '0;
                            n_pay_count    = '0;
                            n_trailer_seen = 1'b0;
                        end
                    end
                    default: begin
                        n_phase = PH_LENGTH;
                    end
                endcase
            end
        end
    end

    // Store writes and result emission.
    always_comb begin
        w_store_we  = 1'b0;
        w_store_idx = '0;
        w_emit      = 1'b0;
        if (w_accept && !r_hunting) begin
            unique case (r_phase)
                PH_LENGTH: begin
                    w_store_we = 1'b0;
                end
                PH_PAYLOAD: begin
                    w_store_we  = (r_pay_count < 8'(STORE_DEPTH));
                    w_store_idx = r_pay_count[STORE_AW-1:0];
                end
                PH_CHECKSUM: begin
                    w_store_we  = (r_frame_len != 8'd0) && (w_len_m1 < 8'(STORE_DEPTH));
                    w_store_idx = w_len_m1[STORE_AW-1:0];
                end
                PH_TRAILER: begin
                    w_emit = r_trailer_seen;
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting      <= 1'b1;
            r_prev_byte    <= '0;
            r_phase        <= PH_LENGTH;
            r_frame_len    <= '0;
            r_pay_count    <= '0;
            r_trailer_seen <= 1'b0;
        end else begin
            r_hunting      <= n_hunting;
            r_prev_byte    <= n_prev_byte;
            r_phase        <= n_phase;
            r_frame_len    <= n_frame_len;
            r_pay_count    <= n_pay_count;
            r_trailer_seen <= n_trailer_seen;
        end
    end

    // Payload store, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else if (w_store_we) begin
            r_store[w_store_idx] <= w_byte;
        end
    end

    // Little-endian assembly of the two values.
    assign w_pair.first_value  = $signed({r_store[3], r_store[2], r_store[1], r_store[0]});
    assign w_pair.second_value = $signed({r_store[7], r_store[6], r_store[5], r_store[4]});

    sfpp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_emit),
        .i_data  (w_pair),
        .o_full  (w_full),
        .o_pair  (o_pair)
    );

endmodule
